@@ rtl/gpio_lk_pkg.sv @@
// Shared types and constants of the GPIO port with lock key.
// No dependencies; every other file of the block imports this package.
package gpio_lk_pkg;

   // Access direction codes.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Register select codes.
   localparam logic [2:0] SEL_CFG_LOW  = 3'd0;
   localparam logic [2:0] SEL_CFG_HIGH = 3'd1;
   localparam logic [2:0] SEL_INPUT    = 3'd2;
   localparam logic [2:0] SEL_LATCH    = 3'd3;
   localparam logic [2:0] SEL_SET_RST  = 3'd4;
   localparam logic [2:0] SEL_RESET    = 3'd5;
   localparam logic [2:0] SEL_LOCK     = 3'd6;

   // Configuration reset value: every pin a floating input.
   localparam logic [31:0] CFG_RESET = 32'h4444_4444;
   // Bit position of the key in the lock register.
   localparam int KEY_BIT = 16;
   localparam logic [3:0] NIBBLE = 4'hf;

   // One bus transaction as held in the input register.
   typedef struct packed {
      logic        wr;
      logic [2:0]  sel;
      logic [31:0] data;
      logic [15:0] levels;
   } access_type;

   // Lock register contents as seen by the register file.
   typedef struct packed {
      logic        key;
      logic [15:0] pins;
   } lock_status_type;

   // Lock key sequence position, one-hot.
   typedef enum logic [3:0] {
      PHASE_IDLE  = 4'b0001,
      PHASE_FIRST = 4'b0010,
      PHASE_ZERO  = 4'b0100,
      PHASE_ARMED = 4'b1000
   } lock_phase_type;

endpackage

@@ rtl/gpio_port_with_lock_key.sv @@
// GPIO port with lock key: a 16-pin port behind bus registers; each request
// transaction is one register access plus the sampled pin levels, and yields
// exactly one response transaction with the read data, the output latch and
// the lock state after the access. The block takes one transaction per clock
// while the response side does not stall; each one passes through the input
// register and then the response register. While a response waits, one more
// request is still taken into the input register. Reset restores all
// configuration nibbles to floating input, clears the output latch and
// releases the lock. Depends on gpio_lk_pkg, gpio_lk_regs and gpio_lk_lock.
module gpio_port_with_lock_key
   import gpio_lk_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_reg_select,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [15:0] rsp_pin_drive,
   output logic        rsp_lock_active
);

   logic            in_valid_ff;
   access_type      in_acc_ff;
   logic            out_valid_ff;
   logic [31:0]     read_data_ff;
   logic [15:0]     pin_drive_ff;
   logic            lock_active_ff;

   logic            advance;
   logic [31:0]     read_data;
   logic [15:0]     latch_next;
   logic            key_next;
   lock_status_type lock_status;

   // The held transaction executes when the response register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_acc_ff.wr     <= req_kind;
         in_acc_ff.sel    <= req_reg_select;
         in_acc_ff.data   <= req_write_data;
         in_acc_ff.levels <= req_pin_levels;
      end
   end

   gpio_lk_lock #(
      .PIN_COUNT (PIN_COUNT)
   ) u_lock (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .acc      (in_acc_ff),
      .status   (lock_status),
      .key_next (key_next)
   );

   gpio_lk_regs #(
      .PIN_COUNT (PIN_COUNT)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .acc        (in_acc_ff),
      .status     (lock_status),
      .read_data  (read_data),
      .latch_next (latch_next)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff   <= read_data;
         pin_drive_ff   <= latch_next;
         lock_active_ff <= key_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = read_data_ff;
   assign rsp_pin_drive   = pin_drive_ff;
   assign rsp_lock_active = lock_active_ff;

`ifndef SYNTHESIS
   // Only reset releases the lock.
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(lock_status.key))
      else $error("lock key cleared without reset");

   // Lock state moves only with an executed transaction.
   a_lock_quiet: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(lock_status))
      else $error("lock state changed without a transaction");

   // A response produced while locked reports the lock.
   a_lock_reported: assert property (@(posedge clock) disable iff (reset)
      (advance && lock_status.key) |=> (rsp_valid && rsp_lock_active))
      else $error("response does not report the active lock");

   // A held transaction never executes into an occupied, stalled response.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("response overwritten while stalled");
`endif

endmodule

@@ rtl/gpio_lk_lock.sv @@
// Lock register and lock key sequencer of the GPIO port.
// Depends on gpio_lk_pkg.
module gpio_lk_lock
   import gpio_lk_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  access_type      acc,
   output lock_status_type status,
   output logic            key_next
);

   localparam logic [15:0] PinMask = 16'((33'h1 << PIN_COUNT) - 33'h1);

   lock_phase_type phase_ff, phase_in;
   logic           key_ff, key_in;
   logic [15:0]    pins_ff, pins_in;

   logic [15:0] wr_pins;
   logic        wr_key;
   logic        same;

   assign wr_pins = acc.data[15:0] & PinMask;
   assign wr_key  = acc.data[KEY_BIT];
   assign same    = wr_pins == pins_ff;

   // Sequence steps; nothing moves once the key is set.
   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      pins_in  = pins_ff;
      if (fire && !key_ff && acc.sel == SEL_LOCK) begin
         if (acc.wr == KIND_WRITE) begin
            pins_in = wr_pins;
            if (phase_ff == PHASE_FIRST && !wr_key && same) begin
               phase_in = PHASE_ZERO;
            end else if (phase_ff == PHASE_ZERO && wr_key && same) begin
               phase_in = PHASE_ARMED;
            end else begin
               phase_in = wr_key ? PHASE_FIRST : PHASE_IDLE;
            end
         end else begin
            // A read completes an armed sequence and aborts any other.
            if (phase_ff == PHASE_ARMED) begin
               key_in = 1'b1;
            end
            phase_in = PHASE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         key_ff   <= 1'b0;
         pins_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
         pins_ff  <= pins_in;
      end
   end

   assign status.key  = key_ff;
   assign status.pins = pins_ff;
   assign key_next    = key_in;

endmodule

@@ rtl/gpio_lk_regs.sv @@
// Configuration words, output latch and read data selection of the GPIO port.
// Depends on gpio_lk_pkg and on the lock status from gpio_lk_lock.
module gpio_lk_regs
   import gpio_lk_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  access_type      acc,
   input  lock_status_type status,
   output logic [31:0]     read_data,
   output logic [15:0]     latch_next
);

   localparam logic [15:0] PinMask = 16'((33'h1 << PIN_COUNT) - 33'h1);

   logic [31:0] cfg_low_ff, cfg_low_in;
   logic [31:0] cfg_high_ff, cfg_high_in;
   logic [15:0] latch_ff, latch_in;
   logic [31:0] low_mask, high_mask;

   // Nibbles that a write may change: present pins that are not locked.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         low_mask[4*i +: 4]  = (i < PIN_COUNT && !(status.key && status.pins[i]))
                               ? NIBBLE : 4'h0;
         high_mask[4*i +: 4] = (i + 8 < PIN_COUNT && !(status.key && status.pins[i + 8]))
                               ? NIBBLE : 4'h0;
      end
   end

   // Register writes.
   always_comb begin
      cfg_low_in  = cfg_low_ff;
      cfg_high_in = cfg_high_ff;
      latch_in    = latch_ff;
      if (fire && acc.wr == KIND_WRITE) begin
         case (acc.sel)
            SEL_CFG_LOW: begin
               cfg_low_in = (cfg_low_ff & ~low_mask) | (acc.data & low_mask);
            end
            SEL_CFG_HIGH: begin
               cfg_high_in = (cfg_high_ff & ~high_mask) | (acc.data & high_mask);
            end
            SEL_LATCH: begin
               latch_in = acc.data[15:0] & PinMask;
            end
            SEL_SET_RST: begin
               // Set wins over reset for a bit named in both halves.
               latch_in = (latch_ff & ~(acc.data[31:16] & PinMask))
                          | (acc.data[15:0] & PinMask);
            end
            SEL_RESET: begin
               latch_in = latch_ff & ~(acc.data[15:0] & PinMask);
            end
            default: begin
            end
         endcase
      end
   end

   // Read data comes from the state before this transaction.
   always_comb begin
      read_data = '0;
      if (acc.wr == KIND_READ) begin
         case (acc.sel)
            SEL_CFG_LOW:  read_data = cfg_low_ff;
            SEL_CFG_HIGH: read_data = cfg_high_ff;
            SEL_INPUT:    read_data = {16'h0, acc.levels & PinMask};
            SEL_LATCH:    read_data = {16'h0, latch_ff};
            SEL_LOCK:     read_data = {15'h0, status.key, status.pins};
            default:      read_data = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff  <= CFG_RESET;
         cfg_high_ff <= CFG_RESET;
         latch_ff    <= '0;
      end else begin
         cfg_low_ff  <= cfg_low_in;
         cfg_high_ff <= cfg_high_in;
         latch_ff    <= latch_in;
      end
   end

   assign latch_next = latch_in;

endmodule

@@ bench/gpio_lk_checker.sv @@
// Response checker of the GPIO port with lock key: mirrors the register file and
// lock key sequence from the accepted requests and compares every response.
// Depends on gpio_lk_pkg for the register codes, reset values and lock phase type.
`timescale 1ns / 100ps

module gpio_lk_checker
   import gpio_lk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_reg_select,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_pin_levels,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic [15:0] rsp_pin_drive,
   input  logic        rsp_lock_active,
   output int          mismatch_count,
   output int          responses_due
);

   localparam int PINS = 16;
   localparam logic [15:0] PIN_MASK = 16'hffff;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_drive;
      logic        lock_active;
   } port_response_type;

   port_response_type port_responses_due[$];

   // Mirror of the port registers.
   logic [31:0]    cfg_low;
   logic [31:0]    cfg_high;
   logic [15:0]    latch;
   logic [15:0]    lock_pins;
   logic           lock_key;
   lock_phase_type lock_phase;
   int             errors = 0;

   assign mismatch_count = errors;

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: mismatch on %s, got %h, expected %h", $realtime, field, got, want);
      errors++;
   endtask

   // Nibbles of a configuration word that a write may change; first is pin 0 or 8.
   function automatic logic [31:0] cfg_write_mask(input int first);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (first + i < PINS && !(lock_key && lock_pins[first + i])) begin
            m[4*i +: 4] = NIBBLE;
         end
      end
      return m;
   endfunction

   // A lock register write advances, restarts or aborts the key sequence.
   function automatic void write_lock(input logic [31:0] data);
      logic [15:0] pins;
      logic        key;
      pins = data[15:0] & PIN_MASK;
      key  = data[KEY_BIT];
      if (lock_key) begin
         return;
      end
      if (lock_phase == PHASE_FIRST && !key && pins == lock_pins) begin
         lock_phase = PHASE_ZERO;
      end else if (lock_phase == PHASE_ZERO && key && pins == lock_pins) begin
         lock_phase = PHASE_ARMED;
      end else if (key) begin
         lock_phase = PHASE_FIRST;
      end else begin
         lock_phase = PHASE_IDLE;
      end
      lock_pins = pins;
   endfunction

   // A lock register read completes an armed sequence and aborts any other.
   function automatic logic [31:0] read_lock();
      logic [31:0] v;
      v = '0;
      v[KEY_BIT] = lock_key;
      v[15:0]    = lock_pins;
      if (!lock_key) begin
         if (lock_phase == PHASE_ARMED) begin
            lock_key = 1'b1;
         end
         lock_phase = PHASE_IDLE;
      end
      return v;
   endfunction

   // Applies one bus access to the mirror and returns the response it yields.
   function automatic port_response_type apply_access(input logic wr, input logic [2:0] sel,
                                                      input logic [31:0] data,
                                                      input logic [15:0] levels);
      port_response_type r;
      logic [31:0]       m;
      r = '0;
      if (wr == KIND_WRITE) begin
         case (sel)
            SEL_CFG_LOW: begin
               m = cfg_write_mask(0);
               cfg_low = (cfg_low & ~m) | (data & m);
            end
            SEL_CFG_HIGH: begin
               m = cfg_write_mask(8);
               cfg_high = (cfg_high & ~m) | (data & m);
            end
            SEL_LATCH: latch = data[15:0] & PIN_MASK;
            SEL_SET_RST: begin
               latch = latch & ~(data[31:16] & PIN_MASK);
               latch = latch | (data[15:0] & PIN_MASK);
            end
            SEL_RESET: latch = latch & ~(data[15:0] & PIN_MASK);
            SEL_LOCK: write_lock(data);
            default: ;
         endcase
      end else begin
         case (sel)
            SEL_CFG_LOW:  r.read_data = cfg_low;
            SEL_CFG_HIGH: r.read_data = cfg_high;
            SEL_INPUT:    r.read_data = {16'h0000, levels & PIN_MASK};
            SEL_LATCH:    r.read_data = {16'h0000, latch};
            SEL_LOCK:     r.read_data = read_lock();
            default:      r.read_data = '0;
         endcase
      end
      r.pin_drive   = latch;
      r.lock_active = lock_key;
      return r;
   endfunction

   // Compare each response transaction with the oldest prediction, then
   // predict the response of a request transaction accepted at this edge.
   always @(posedge clock) begin
      port_response_type want;
      if (reset) begin
         cfg_low    = CFG_RESET;
         cfg_high   = CFG_RESET;
         latch      = '0;
         lock_pins  = '0;
         lock_key   = 1'b0;
         lock_phase = PHASE_IDLE;
         port_responses_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (port_responses_due.size() == 0) begin
               flag_mismatch("unexpected response, read_data", rsp_read_data, '0);
            end else begin
               want = port_responses_due.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  flag_mismatch("read_data", rsp_read_data, want.read_data);
               end
               if (rsp_pin_drive !== want.pin_drive) begin
                  flag_mismatch("pin_drive", {16'h0000, rsp_pin_drive},
                                {16'h0000, want.pin_drive});
               end
               if (rsp_lock_active !== want.lock_active) begin
                  flag_mismatch("lock_active", {31'h0, rsp_lock_active},
                                {31'h0, want.lock_active});
               end
            end
         end
         if (req_valid && req_ready) begin
            port_responses_due.push_back(apply_access(req_kind, req_reg_select,
                                                      req_write_data, req_pin_levels));
         end
      end
      responses_due <= port_responses_due.size();
   end

endmodule

@@ bench/tb_gpio_port_with_lock_key.sv @@
// Testbench top of the GPIO port with lock key: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on gpio_lk_pkg, the port RTL
// and gpio_lk_checker, which predicts and compares the responses.
`timescale 1ns / 100ps

module tb_gpio_port_with_lock_key;
   import gpio_lk_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int TOTAL_ITEMS  = 1425;
   // The one select code that names no register.
   localparam logic [2:0] SEL_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_READ;
   logic [2:0]  req_reg_select = SEL_CFG_LOW;
   logic [31:0] req_write_data = '0;
   logic [15:0] req_pin_levels = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic [15:0] rsp_pin_drive;
   logic        rsp_lock_active;

   int mismatch_count;
   int responses_due;
   int items_sent = 0;
   int cycle_count = 0;
   int rsp_hold = 1;
   // When set, neither side idles, giving back-to-back stretches.
   bit steady = 1'b0;

   gpio_port_with_lock_key DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_reg_select  (req_reg_select),
      .req_write_data  (req_write_data),
      .req_pin_levels  (req_pin_levels),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_pin_drive   (rsp_pin_drive),
      .rsp_lock_active (rsp_lock_active)
   );

   gpio_lk_checker port_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_reg_select  (req_reg_select),
      .req_write_data  (req_write_data),
      .req_pin_levels  (req_pin_levels),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_pin_drive   (rsp_pin_drive),
      .rsp_lock_active (rsp_lock_active),
      .mismatch_count  (mismatch_count),
      .responses_due   (responses_due)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side: after each accepted transaction, stall for a random count.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 1;
      end else if (rsp_valid && rsp_ready) begin
         stall = steady ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= stall;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold <= 1) begin
            rsp_ready <= 1'b1;
         end
         rsp_hold <= rsp_hold - 1;
      end
   end

   // Presents one request transaction after a random gap and waits for acceptance.
   // Valid stays high on return, so a back-to-back transaction keeps it high.
   task automatic send_access(input logic kind, input logic [2:0] sel,
                              input logic [31:0] data, input logic [15:0] levels);
      int gap;
      if (items_sent % 50 == 0) begin
         steady = ($urandom_range(0, 3) == 0);
      end
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_reg_select <= sel;
      req_write_data <= data;
      req_pin_levels <= levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Any access at all, including lock accesses and the unused select.
   task automatic send_noise();
      send_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                  16'($urandom_range(0, 65535)));
   endtask

   // Any access that leaves the lock key sequence alone.
   task automatic send_filler();
      logic [2:0] sel;
      do begin
         sel = 3'($urandom_range(0, 7));
      end while (sel == SEL_LOCK);
      send_access(1'($urandom_range(0, 1)), sel, $urandom, 16'($urandom_range(0, 65535)));
   endtask

   // Lock register word with the key bit and pin bits given, random upper bits.
   function automatic logic [31:0] lock_word(input logic key, input logic [15:0] pins);
      logic [31:0] w;
      w = $urandom;
      w[KEY_BIT] = key;
      w[15:0] = pins;
      return w;
   endfunction

   // Lock key sequence with random pins and fillers in between. Unless it is
   // to be completed, it is broken after the write step stop_at.
   task automatic try_lock_key(input bit complete);
      logic [15:0] pins;
      logic [15:0] other;
      int          stop_at;
      int          choice;
      pins    = 16'($urandom);
      stop_at = complete ? 4 : $urandom_range(0, 2);
      for (int step = 0; step < 4; step++) begin
         if (step == 3) begin
            send_access(KIND_READ, SEL_LOCK, $urandom, 16'($urandom));
         end else begin
            send_access(KIND_WRITE, SEL_LOCK, lock_word(step != 1, pins), 16'($urandom));
         end
         if (step == stop_at) begin
            // Break by a read before arming, or by a write with other pins.
            other  = pins ^ 16'($urandom_range(1, 65535));
            choice = $urandom_range(stop_at < 2 ? 0 : 1, 2);
            if (choice == 0) begin
               send_access(KIND_READ, SEL_LOCK, $urandom, 16'($urandom));
            end else begin
               send_access(KIND_WRITE, SEL_LOCK, lock_word(choice == 1, other),
                           16'($urandom));
            end
            break;
         end
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_filler();
      end
   endtask

   // Field extremes, every register in both directions and the sequence aborts.
   task automatic run_directed();
      send_access(KIND_READ,  SEL_CFG_LOW,  32'hffff_ffff, 16'h0000);
      send_access(KIND_READ,  SEL_CFG_HIGH, 32'h0000_0000, 16'hffff);
      send_access(KIND_READ,  SEL_INPUT,    32'h0000_0000, 16'hffff);
      send_access(KIND_READ,  SEL_INPUT,    32'hffff_ffff, 16'h0000);
      send_access(KIND_WRITE, SEL_LATCH,    32'hffff_ffff, 16'h5a5a);
      send_access(KIND_READ,  SEL_LATCH,    32'h0000_0000, 16'ha5a5);
      // Bits named in both halves of the set/reset word end up set.
      send_access(KIND_WRITE, SEL_SET_RST,  32'h00ff_0f0f, 16'h0000);
      send_access(KIND_WRITE, SEL_RESET,    32'hffff_f000, 16'hffff);
      send_access(KIND_READ,  SEL_SET_RST,  32'hffff_ffff, 16'h0000);
      send_access(KIND_READ,  SEL_RESET,    32'hffff_ffff, 16'h0000);
      send_access(KIND_WRITE, SEL_INPUT,    32'hffff_ffff, 16'hffff);
      send_access(KIND_WRITE, SEL_UNUSED,   32'hffff_ffff, 16'hffff);
      send_access(KIND_READ,  SEL_UNUSED,   32'hffff_ffff, 16'hffff);
      send_access(KIND_WRITE, SEL_CFG_LOW,  32'hffff_ffff, 16'h0000);
      send_access(KIND_WRITE, SEL_CFG_HIGH, 32'h0000_0000, 16'h0000);
      // A read in the middle of the sequence aborts it.
      send_access(KIND_WRITE, SEL_LOCK,     32'h0001_00f0, 16'h0000);
      send_access(KIND_READ,  SEL_LOCK,     32'h0000_0000, 16'h0000);
      // A write with changed pins and the key bit clear aborts the sequence.
      send_access(KIND_WRITE, SEL_LOCK,     32'h0001_1234, 16'h0000);
      send_access(KIND_WRITE, SEL_LOCK,     32'h0000_1234, 16'h0000);
      send_access(KIND_WRITE, SEL_LOCK,     32'hfffe_4321, 16'h0000);
      send_access(KIND_WRITE, SEL_LOCK,     32'h0000_4321, 16'h0000);
      send_access(KIND_READ,  SEL_LOCK,     32'h0000_0000, 16'h0000);
      send_access(KIND_WRITE, SEL_LOCK,     32'h0000_ffff, 16'h0000);
      send_access(KIND_READ,  SEL_LOCK,     32'h0000_0000, 16'h0000);
      send_access(KIND_WRITE, SEL_LATCH,    32'h0000_0000, 16'h0000);
   endtask

   // Stimulus: directed accesses, random traffic with broken lock sequences,
   // then one completed sequence and random traffic against the frozen lock.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 6) begin
            send_noise();
         end else begin
            try_lock_key(1'b0);
         end
      end
      try_lock_key(1'b1);
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            send_noise();
         end else begin
            try_lock_key(1'b0);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
